[rtl/core/wav_hdr_pkg.sv]
// ----------------------------------------------------------------------------
// wav_hdr_pkg
// Status codes, tags, header offsets and the result record of the WAV header
// parser.
// ----------------------------------------------------------------------------
package wav_hdr_pkg;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SMALL  = 3'd1;
    localparam logic [2:0] ST_RIFF   = 3'd2;
    localparam logic [2:0] ST_WAVE   = 3'd3;
    localparam logic [2:0] ST_FMT    = 3'd4;
    localparam logic [2:0] ST_PCM    = 3'd5;
    localparam logic [2:0] ST_BITS   = 3'd6;
    localparam logic [2:0] ST_NODATA = 3'd7;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [7:0]  FMT_PCM        = 8'd1;
    localparam logic [7:0]  BITS_16        = 8'd16;
    localparam logic [5:0]  HDR_LAST_POS   = 6'd35;
    localparam logic [31:0] REPORT_POS     = 32'd43;
    localparam logic [31:0] CHUNK_HDR_LEN  = 32'd8;
    localparam logic [33:0] CHUNK_SPAN_ADD = 34'd9;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [31:0] pcm_offset;
        logic [31:0] pcm_size;
    } t_result;

    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        logic [31:0] sh;
        sh = tag >> {2'd3 - idx, 3'b000};
        return sh[7:0];
    endfunction

    function automatic t_result make_result(
        input logic [2:0]  status,
        input logic [31:0] rate,
        input logic [15:0] chans,
        input logic [31:0] ofs,
        input logic [31:0] size
    );
        t_result r;
        r.status        = status;
        r.sample_rate   = (status == ST_OK) ? rate  : 32'd0;
        r.channel_count = (status == ST_OK) ? chans : 16'd0;
        r.pcm_offset    = (status == ST_OK) ? ofs   : 32'd0;
        r.pcm_size      = (status == ST_OK) ? size  : 32'd0;
        return r;
    endfunction

endpackage

[rtl/core/wav_header_parser_unit.sv]
// ----------------------------------------------------------------------------
// wav_header_parser_unit
// Byte-serial WAV header parser: checks the fixed header, walks the chunk
// list to the data chunk and reports one status record per file.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | i_in_valid, o_in_stall, byte, eof    | sink
//   out     | o_out_valid, i_out_stall, 5 fields   | source
//
// One byte transfer per cycle while o_in_stall is low; a result is registered
// into the output register, or into the skid while the output is stalled.
// A one-entry skid behind the output register absorbs a result while the
// output is stalled; o_in_stall is high only while the skid is occupied.
// i_rst_n (synchronous, active low) clears the parse state and both valids.
// ----------------------------------------------------------------------------
module wav_header_parser_unit
    import wav_hdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_sample_rate,
    output logic [15:0] o_channel_count,
    output logic [31:0] o_pcm_offset,
    output logic [31:0] o_pcm_size
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_CHUNK  = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [31:0] r_pos,   n_pos;
    logic [2:0]  r_err,   n_err;
    logic [31:0] r_rate,  n_rate;
    logic [15:0] r_chan,  n_chan;
    logic [63:0] r_shift, n_shift;
    logic [31:0] r_skip,  n_skip;
    logic [1:0]  r_phase, n_phase;

    logic        r_out_valid, r_skd_valid;
    t_result     r_out, r_skd;

    logic        accept, out_take, res_hit;
    t_result     res;
    logic [5:0]  hp;
    logic [63:0] shift_cat;
    logic [31:0] chunk_size, skip_left;
    logic [33:0] span;

    assign accept     = i_in_valid && !r_skd_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign hp         = r_pos[5:0];
    assign shift_cat  = {r_shift[55:0], i_file_byte};
    assign chunk_size = {shift_cat[7:0], shift_cat[15:8], shift_cat[23:16], shift_cat[31:24]};
    assign skip_left  = (r_skip != 32'd0) ? (r_skip - 32'd1) : r_skip;
    assign span       = {2'b00, r_pos} + {2'b00, chunk_size} + CHUNK_SPAN_ADD;

    always_comb begin
        n_pos   = r_pos;
        n_err   = r_err;
        n_rate  = r_rate;
        n_chan  = r_chan;
        n_shift = r_shift;
        n_skip  = r_skip;
        n_phase = r_phase;
        res_hit = 1'b0;
        res     = '0;
        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (hp < 6'd4) begin
                        if (i_file_byte != tag_byte(TAG_RIFF, hp[1:0]) && r_err == ST_OK)
                            n_err = ST_RIFF;
                    end else if (hp >= 6'd8 && hp < 6'd12) begin
                        if (i_file_byte != tag_byte(TAG_WAVE, hp[1:0]) && r_err == ST_OK)
                            n_err = ST_WAVE;
                    end else if (hp >= 6'd12 && hp < 6'd16) begin
                        if (i_file_byte != tag_byte(TAG_FMT, hp[1:0]) && r_err == ST_OK)
                            n_err = ST_FMT;
                    end else if (hp == 6'd20) begin
                        if (i_file_byte != FMT_PCM && r_err == ST_OK)
                            n_err = ST_PCM;
                    end else if (hp == 6'd21) begin
                        if (i_file_byte != 8'd0 && r_err == ST_OK)
                            n_err = ST_PCM;
                    end else if (hp == 6'd22) begin
                        n_chan[7:0] = i_file_byte;
                    end else if (hp == 6'd23) begin
                        n_chan[15:8] = i_file_byte;
                    end else if (hp >= 6'd24 && hp < 6'd28) begin
                        n_rate[{hp[1:0], 3'b000} +: 8] = i_file_byte;
                    end else if (hp == 6'd34) begin
                        if (i_file_byte != BITS_16 && r_err == ST_OK)
                            n_err = ST_BITS;
                    end else if (hp == 6'd35) begin
                        if (i_file_byte != 8'd0 && r_err == ST_OK)
                            n_err = ST_BITS;
                    end
                    if (hp == HDR_LAST_POS) begin
                        n_phase = PH_CHUNK;
                        n_skip  = CHUNK_HDR_LEN;
                        n_shift = '0;
                    end
                end
                PH_CHUNK: begin
                    n_shift = shift_cat;
                    n_skip  = skip_left;
                    if (r_pos == REPORT_POS && r_err != ST_OK) begin
                        res_hit = 1'b1;
                        res     = make_result(r_err, r_rate, r_chan, 32'd0, 32'd0);
                        n_phase = PH_DONE;
                    end else if (skip_left == 32'd0) begin
                        if (shift_cat[63:32] == TAG_DATA) begin
                            res_hit = 1'b1;
                            res     = make_result(ST_OK, r_rate, r_chan, r_pos + 32'd1,
                                                  chunk_size);
                            n_phase = PH_DONE;
                        end else if (span[33:32] != 2'b00) begin
                            res_hit = 1'b1;
                            res     = make_result(ST_NODATA, r_rate, r_chan, 32'd0, 32'd0);
                            n_phase = PH_DONE;
                        end else if (chunk_size == 32'd0) begin
                            n_skip  = CHUNK_HDR_LEN;
                            n_shift = '0;
                        end else begin
                            n_skip  = chunk_size;
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_left;
                    if (skip_left == 32'd0) begin
                        n_phase = PH_CHUNK;
                        n_skip  = CHUNK_HDR_LEN;
                        n_shift = '0;
                    end
                end
                default: begin
                end
            endcase
            n_pos = r_pos + 32'd1;
            if (i_end_of_file) begin
                if (!res_hit && r_phase != PH_DONE) begin
                    res_hit = 1'b1;
                    res     = make_result((r_pos < REPORT_POS) ? ST_SMALL : ST_NODATA,
                                          r_rate, r_chan, 32'd0, 32'd0);
                end
                n_pos   = '0;
                n_err   = ST_OK;
                n_rate  = '0;
                n_chan  = '0;
                n_shift = '0;
                n_skip  = '0;
                n_phase = PH_HEADER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_err   <= ST_OK;
            r_rate  <= '0;
            r_chan  <= '0;
            r_shift <= '0;
            r_skip  <= '0;
            r_phase <= PH_HEADER;
        end else begin
            r_pos   <= n_pos;
            r_err   <= n_err;
            r_rate  <= n_rate;
            r_chan  <= n_chan;
            r_shift <= n_shift;
            r_skip  <= n_skip;
            r_phase <= n_phase;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (out_take) begin
                r_out       <= r_skd;
                r_skd_valid <= 1'b0;
            end
        end else if (res_hit) begin
            if (!r_out_valid || out_take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skd       <= res;
                r_skd_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall      = r_skd_valid;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_sample_rate   = r_out.sample_rate;
    assign o_channel_count = r_out.channel_count;
    assign o_pcm_offset    = r_out.pcm_offset;
    assign o_pcm_size      = r_out.pcm_size;

endmodule

[tb/wav_header_parser_checker.sv]
// ----------------------------------------------------------------------------
// wav_header_parser_checker
// Watches both channels of the WAV header parser. Every byte transfer runs
// through a local copy of the parse state; the status record that a byte
// produces is queued and each output transfer is compared field by field
// with the oldest queued record.
// ----------------------------------------------------------------------------
module wav_header_parser_checker
    import wav_hdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_end_of_file,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_sample_rate,
    input  logic [15:0] i_channel_count,
    input  logic [31:0] i_pcm_offset,
    input  logic [31:0] i_pcm_size,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_FIXED,
        PH_CHUNK_HDR,
        PH_CHUNK_BODY,
        PH_DONE
    } t_phase;

    localparam logic [2:0] ERR_NONE = ST_OK;

    t_result     records_due[$];
    logic [31:0] pos_r;
    logic [2:0]  hdr_err;
    logic [31:0] rate_cap;
    logic [15:0] chan_cap;
    logic [63:0] chunk_sh;
    logic [32:0] remain;
    t_phase      phase;
    logic        sent;
    int unsigned fails = 0;
    int unsigned checked = 0;

    function automatic void clear_parser();
        pos_r    = '0;
        hdr_err  = ERR_NONE;
        rate_cap = '0;
        chan_cap = '0;
        chunk_sh = '0;
        remain   = '0;
        phase    = PH_FIXED;
        sent     = 1'b0;
    endfunction

    function automatic logic [7:0] tag_at(input logic [31:0] tag, input logic [1:0] k);
        return tag[8 * (3 - k) +: 8];
    endfunction

    function automatic void note_err(input logic [2:0] code);
        if (hdr_err == ERR_NONE) begin
            hdr_err = code;
        end
    endfunction

    function automatic void record_result(input logic [2:0] st, input logic [31:0] ofs,
                                          input logic [31:0] size);
        t_result r;
        r.status        = st;
        r.sample_rate   = (st == ST_OK) ? rate_cap : '0;
        r.channel_count = (st == ST_OK) ? chan_cap : '0;
        r.pcm_offset    = (st == ST_OK) ? ofs : '0;
        r.pcm_size      = (st == ST_OK) ? size : '0;
        records_due.push_back(r);
        sent  = 1'b1;
        phase = PH_DONE;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic eof);
        logic [31:0] p;
        logic [31:0] lo;
        logic [31:0] size_le;
        logic        made;
        p    = pos_r;
        made = 1'b0;
        case (phase)
            PH_FIXED: begin
                if (p < 4) begin
                    if (b != tag_at(TAG_RIFF, p[1:0])) note_err(ST_RIFF);
                end else if (p >= 8 && p < 12) begin
                    if (b != tag_at(TAG_WAVE, p[1:0])) note_err(ST_WAVE);
                end else if (p >= 12 && p < 16) begin
                    if (b != tag_at(TAG_FMT, p[1:0])) note_err(ST_FMT);
                end else if (p == 20) begin
                    if (b != FMT_PCM) note_err(ST_PCM);
                end else if (p == 21) begin
                    if (b != 8'd0) note_err(ST_PCM);
                end else if (p == 22 || p == 23) begin
                    chan_cap[{p[0], 3'b000} +: 8] = chan_cap[{p[0], 3'b000} +: 8] | b;
                end else if (p >= 24 && p < 28) begin
                    rate_cap[{p[1:0], 3'b000} +: 8] = rate_cap[{p[1:0], 3'b000} +: 8] | b;
                end else if (p == 34) begin
                    if (b != BITS_16) note_err(ST_BITS);
                end else if (p == 35) begin
                    if (b != 8'd0) note_err(ST_BITS);
                end
                if (p >= HDR_LAST_POS) begin
                    phase    = PH_CHUNK_HDR;
                    remain   = {1'b0, CHUNK_HDR_LEN};
                    chunk_sh = '0;
                end
            end
            PH_CHUNK_HDR: begin
                chunk_sh = {chunk_sh[55:0], b};
                if (remain != 0) remain = remain - 1;
                if (p == REPORT_POS && hdr_err != ERR_NONE) begin
                    record_result(hdr_err, '0, '0);
                    made = 1'b1;
                end else if (remain == 0) begin
                    lo      = chunk_sh[31:0];
                    size_le = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]};
                    if (chunk_sh[63:32] == TAG_DATA) begin
                        record_result(ST_OK, p + 1, size_le);
                        made = 1'b1;
                    end else if ({2'b00, p} + {2'b00, size_le} + CHUNK_SPAN_ADD
                                 > 34'h0_FFFF_FFFF) begin
                        // next header would run past the 32-bit range
                        record_result(ST_NODATA, '0, '0);
                        made = 1'b1;
                    end else if (size_le == 0) begin
                        remain   = {1'b0, CHUNK_HDR_LEN};
                        chunk_sh = '0;
                    end else begin
                        remain = {1'b0, size_le};
                        phase  = PH_CHUNK_BODY;
                    end
                end
            end
            PH_CHUNK_BODY: begin
                if (remain != 0) remain = remain - 1;
                if (remain == 0) begin
                    phase    = PH_CHUNK_HDR;
                    remain   = {1'b0, CHUNK_HDR_LEN};
                    chunk_sh = '0;
                end
            end
            default: begin
            end
        endcase
        pos_r = p + 1;
        if (eof) begin
            if (!made && !sent) begin
                record_result((p < REPORT_POS) ? ST_SMALL : ST_NODATA, '0, '0);
            end
            clear_parser();
        end
    endfunction

    function automatic int unsigned check_field(input string name, input logic [31:0] want,
                                                input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_file_byte, i_end_of_file);
            end
            if (i_out_valid && !i_out_stall) begin
                if (records_due.size() == 0) begin
                    $error("status: expected no transfer, actual %0d", i_status);
                    fails++;
                end else begin
                    w = records_due.pop_front();
                    checked++;
                    fails += check_field("status", 32'(w.status), 32'(i_status));
                    fails += check_field("sample_rate", w.sample_rate, i_sample_rate);
                    fails += check_field("channel_count", 32'(w.channel_count),
                                         32'(i_channel_count));
                    fails += check_field("pcm_offset", w.pcm_offset, i_pcm_offset);
                    fails += check_field("pcm_size", w.pcm_size, i_pcm_size);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= records_due.size();
        o_checked    <= checked;
    end

endmodule

[tb/wav_header_parser_unit_tb.sv]
// ----------------------------------------------------------------------------
// wav_header_parser_unit_tb
// Feeds the WAV header parser with whole files: a directed set covering every
// status code and field extreme, then random well-formed, corrupted,
// truncated, noise and out-of-range files. Both channels idle at random and
// the receiver holds off once for a long stretch. The checker beside the
// block predicts and compares every status record.
// ----------------------------------------------------------------------------
module wav_header_parser_unit_tb
    import wav_hdr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_XFERS = 1100;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_AT      = 1500;
    localparam int unsigned HOLD_LEN     = 600;
    localparam logic [31:0] TAG_LIST     = 32'h4C49_5354;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  file_byte = '0;
    logic        end_of_file = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [31:0] pcm_offset;
    logic [31:0] pcm_size;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    logic [7:0]  img[$];
    logic        calm = 1'b0;
    int unsigned xfers = 0;
    int unsigned files = 0;

    wav_header_parser_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_file_byte    (file_byte),
        .i_end_of_file  (end_of_file),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_sample_rate  (sample_rate),
        .o_channel_count(channel_count),
        .o_pcm_offset   (pcm_offset),
        .o_pcm_size     (pcm_size)
    );

    wav_header_parser_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_file_byte    (file_byte),
        .i_end_of_file  (end_of_file),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_sample_rate  (sample_rate),
        .i_channel_count(channel_count),
        .i_pcm_offset   (pcm_offset),
        .i_pcm_size     (pcm_size),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int unsigned cyc;
        for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial begin : receiver
        int unsigned cyc;
        int unsigned hold;
        cyc  = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc == HOLD_AT) hold = HOLD_LEN;
            if (hold != 0) begin
                out_stall <= 1'b1;
                hold--;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 19);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic put_byte(input logic [7:0] b, input logic eof);
        while (!calm && $urandom_range(99) < 19) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        file_byte   <= b;
        end_of_file <= eof;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        xfers++;
        @(negedge i_clk);
    endtask

    task automatic send_file();
        int k;
        for (k = 0; k < img.size(); k++) put_byte(img[k], k == img.size() - 1);
        files++;
    endtask

    task automatic push_le16(input logic [15:0] v);
        img.push_back(v[7:0]);
        img.push_back(v[15:8]);
    endtask

    task automatic push_le32(input logic [31:0] v);
        push_le16(v[15:0]);
        push_le16(v[31:16]);
    endtask

    task automatic push_tag(input logic [31:0] t);
        img.push_back(t[31:24]);
        img.push_back(t[23:16]);
        img.push_back(t[15:8]);
        img.push_back(t[7:0]);
    endtask

    task automatic start_file(input logic [31:0] rate, input logic [15:0] chans);
        img.delete();
        push_tag(TAG_RIFF);
        push_le32($urandom);
        push_tag(TAG_WAVE);
        push_tag(TAG_FMT);
        push_le32(32'd16);
        push_le16({8'd0, FMT_PCM});
        push_le16(chans);
        push_le32(rate);
        push_le32($urandom);
        push_le16(16'($urandom));
        push_le16({8'd0, BITS_16});
    endtask

    task automatic add_chunk(input logic [31:0] tag, input logic [31:0] size,
                             input int unsigned body);
        push_tag(tag);
        push_le32(size);
        repeat (body) img.push_back(8'($urandom));
    endtask

    task automatic trim_to(input int unsigned n);
        while (img.size() > n) void'(img.pop_back());
    endtask

    function automatic logic [31:0] other_tag();
        case ($urandom_range(2))
            0:       return TAG_DATA ^ (32'd1 << $urandom_range(31));
            1:       return TAG_LIST;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_skipped_chunks();
        int unsigned sz;
        repeat ($urandom_range(3)) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24);
            add_chunk(other_tag(), sz, sz);
        end
    endtask

    task automatic random_file();
        int unsigned roll;
        roll = $urandom_range(99);
        start_file($urandom, 16'($urandom));
        if (roll < 60) begin
            add_skipped_chunks();
            add_chunk(TAG_DATA, $urandom, $urandom_range(8));
        end else if (roll < 70) begin
            add_skipped_chunks();
            add_chunk(other_tag(), 32'd4, 4);
            trim_to(img.size() - $urandom_range(7));
        end else if (roll < 80) begin
            img[$urandom_range(35)] ^= 8'($urandom_range(255, 1));
            add_chunk(TAG_DATA, $urandom, $urandom_range(4));
        end else if (roll < 88) begin
            add_chunk(TAG_DATA, $urandom, 0);
            trim_to($urandom_range(50, 1));
        end else if (roll < 94) begin
            img.delete();
            repeat ($urandom_range(60, 1)) img.push_back(8'($urandom));
        end else begin
            add_chunk(other_tag(), $urandom_range(32'hFFFF_FFFF, 32'hFFFF_FF00),
                      $urandom_range(5));
        end
        send_file();
    endtask

    initial begin : stimulus
        int          bad_at[] = '{0, 11, 12, 20, 21, 34, 35};
        int unsigned dir_xfers;
        int unsigned dir_files;
        int unsigned rnd_files;
        repeat (6) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // good files; end mark on the data chunk header, field extremes,
        // odd-sized and empty chunks skipped
        start_file(32'd44100, 16'd2);
        add_chunk(TAG_DATA, 32'd0, 0);
        send_file();
        start_file('1, '1);
        add_chunk(TAG_LIST, 32'd3, 3);
        add_chunk(other_tag(), 32'd0, 0);
        add_chunk(TAG_DATA, '1, 4);
        send_file();
        start_file('0, '0);
        add_chunk(TAG_DATA, 32'h8000_0001, 2);
        send_file();

        // one bad field each, then two bad fields: the first one is reported
        foreach (bad_at[k]) begin
            start_file($urandom, 16'($urandom));
            img[bad_at[k]] ^= 8'h80;
            add_chunk(TAG_DATA, $urandom, 0);
            send_file();
        end
        start_file($urandom, 16'($urandom));
        img[34] ^= 8'h01;
        img[3]  ^= 8'h01;
        add_chunk(TAG_DATA, $urandom, 1);
        send_file();

        // too small: single byte, and one byte short of the report point
        img.delete();
        img.push_back(8'h52);
        send_file();
        start_file($urandom, 16'($urandom));
        add_chunk(TAG_DATA, $urandom, 0);
        trim_to(43);
        send_file();

        // no data chunk: end inside a skipped body, end after an empty chunk
        start_file($urandom, 16'($urandom));
        add_chunk(TAG_LIST, 32'd10, 4);
        send_file();
        start_file($urandom, 16'($urandom));
        add_chunk(other_tag(), 32'd0, 0);
        send_file();

        // chunk size that runs past the 32-bit offset range
        start_file($urandom, 16'($urandom));
        add_chunk(TAG_LIST, 32'hFFFF_FFF0, 3);
        send_file();

        dir_xfers = xfers;
        dir_files = files;
        rnd_files = 0;
        while (xfers < dir_xfers + RANDOM_XFERS) begin
            calm = (rnd_files >= 2 && rnd_files < 8);
            random_file();
            rnd_files++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("summary: %0d files (%0d directed), %0d byte transfers, %0d records checked",
                 files, dir_files, xfers, checked);
        $display("summary: all status codes, truncation, skipped chunks and output hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
